// ===== hw/rtl/ascon_pkg.sv =====
// ----------------------------------------------------------------------------
// ascon_pkg
// Shared types, codes and helper functions for the Ascon-128 AEAD engine.
// ----------------------------------------------------------------------------
package ascon_pkg;

    localparam logic [63:0] ASCON_IV = 64'h80400c0600000000;
    localparam int          NUM_ROUNDS = 12;
    localparam int          RND_W = 4;
    localparam logic [RND_W-1:0] RND_FIRST_FULL = RND_W'(0);
    localparam logic [RND_W-1:0] RND_FIRST_HALF = RND_W'(6);
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(NUM_ROUNDS - 1);

    typedef logic [4:0][63:0] sponge_t;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_AD    = 2'd1,
        OP_MSG   = 2'd2,
        OP_FINAL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_TAG1   = 2'd1,
        KIND_TAG2   = 2'd2,
        KIND_VERIFY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_DECRYPT  = 2'd2,
        REG_NONE     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] block;
        logic [3:0]  nbytes;
        logic        last;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] out_data;
        logic [3:0]  out_bytes;
        logic        auth_ok;
        logic        final_result;
    } out_item_t;

    // round constant: high nibble counts down from f, low nibble counts up
    function automatic logic [7:0] round_const(input logic [RND_W-1:0] r);
        logic [3:0] hi;
        hi = 4'hf - r;
        return {hi, r};
    endfunction

    function automatic logic [63:0] lead_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            m[63-8*i -: 8] = (4'(i) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [63:0] pad_word(input logic [2:0] n);
        logic [63:0] p;
        p = '0;
        for (int i = 0; i < 8; i++)
        begin
            p[63-8*i -: 8] = (3'(i) == n) ? 8'h80 : 8'h00;
        end
        return p;
    endfunction

endpackage

// ===== hw/rtl/ascon_round.sv =====
// ----------------------------------------------------------------------------
// ascon_round
// One round of the Ascon permutation: constant addition, S-box layer and
// linear diffusion layer over the five 64-bit state words.
// ----------------------------------------------------------------------------
module ascon_round (
    input  ascon_pkg::sponge_t s_in,
    input  logic [7:0]         rc,
    output ascon_pkg::sponge_t s_out
);
    import ascon_pkg::*;

    logic [63:0] x0, x1, x2, x3, x4;
    logic [63:0] y0, y1, y2, y3, y4;
    logic [63:0] z0, z1, z2, z3, z4;

    // constant addition and substitution layer
    always_comb
    begin
        x0 = s_in[0] ^ s_in[4];
        x4 = s_in[4] ^ s_in[3];
        x2 = s_in[2] ^ {56'b0, rc} ^ s_in[1];
        x1 = s_in[1];
        x3 = s_in[3];
        y0 = x0 ^ (~x1 & x2);
        y1 = x1 ^ (~x2 & x3);
        y2 = x2 ^ (~x3 & x4);
        y3 = x3 ^ (~x4 & x0);
        y4 = x4 ^ (~x0 & x1);
        z1 = y1 ^ y0;
        z0 = y0 ^ y4;
        z3 = y3 ^ y2;
        z2 = ~y2;
        z4 = y4;
    end

    // linear layer
    assign s_out[0] = z0 ^ {z0[18:0], z0[63:19]} ^ {z0[27:0], z0[63:28]};
    assign s_out[1] = z1 ^ {z1[60:0], z1[63:61]} ^ {z1[38:0], z1[63:39]};
    assign s_out[2] = z2 ^ {z2[0],    z2[63:1]}  ^ {z2[5:0],  z2[63:6]};
    assign s_out[3] = z3 ^ {z3[9:0],  z3[63:10]} ^ {z3[16:0], z3[63:17]};
    assign s_out[4] = z4 ^ {z4[6:0],  z4[63:7]}  ^ {z4[40:0], z4[63:41]};

endmodule

// ===== hw/rtl/ascon128_aead_engine.sv =====
// ----------------------------------------------------------------------------
// ascon128_aead_engine
// Ascon-128 authenticated encryption and decryption with a single shared
// round unit under a small sequencer.
// ----------------------------------------------------------------------------
// The engine takes one input beat at a time and runs one permutation round
// per clock through a single shared round unit. A start or finalize beat
// is accepted and then runs all 12 rounds, an associated data block or a
// non-last message block the last 6 rounds, and a last message block none.
// Each result is handed to the output register from the emit state, the
// encrypt tag pair from the emit state and then the second tag state.
// A new input beat is taken while a result still sits in the output
// register; the engine only stalls when it must load a further result and
// the register has not drained. Configuration writes are accepted every
// cycle and should only be issued while the engine is idle.
// ----------------------------------------------------------------------------
module ascon128_aead_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ascon_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ascon_pkg::out_item_t out_item
);
    import ascon_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_TAG2  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    sponge_t         s_reg, s_next, s_round;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic            post_key_reg, post_key_next;
    logic            emit_reg, emit_next;
    logic            domain_done_reg, domain_done_next;
    logic            ad_seen_reg, ad_seen_next;
    logic [63:0]     key_high_reg, key_low_reg;
    logic            decrypt_mode_reg;
    kind_t           pend_kind_reg, pend_kind_next;
    logic [63:0]     pend_data_reg, pend_data_next;
    logic [3:0]      pend_bytes_reg, pend_bytes_next;
    logic [63:0]     tag_high_reg, tag_high_next;
    logic [63:0]     tag_low_reg, tag_low_next;
    logic            out_valid_reg;
    out_item_t       out_item_reg, out_item_next;
    logic            out_load;
    logic            out_free;
    logic            accept;
    logic [2:0]      n_sat;
    logic [3:0]      nb;
    logic [63:0]     msg_mask;
    logic [63:0]     msg_d;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign n_sat    = (in_item.nbytes > 4'd7) ? 3'd7 : in_item.nbytes[2:0];
    assign nb       = in_item.last ? {1'b0, n_sat} : 4'd8;
    assign msg_mask = lead_mask(nb);
    assign msg_d    = in_item.block & msg_mask;

    ascon_round u_round (
        .s_in  (s_reg),
        .rc    (round_const(rnd_reg)),
        .s_out (s_round)
    );

    always_comb
    begin
        state_next       = state_reg;
        s_next           = s_reg;
        rnd_next         = rnd_reg;
        post_key_next    = post_key_reg;
        emit_next        = emit_reg;
        domain_done_next = domain_done_reg;
        ad_seen_next     = ad_seen_reg;
        pend_kind_next   = pend_kind_reg;
        pend_data_next   = pend_data_reg;
        pend_bytes_next  = pend_bytes_reg;
        tag_high_next    = tag_high_reg;
        tag_low_next     = tag_low_reg;
        out_load         = 1'b0;
        out_item_next    = out_item_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(in_item.op))
                        OP_START:
                        begin
                            s_next[0]        = ASCON_IV;
                            s_next[1]        = key_high_reg;
                            s_next[2]        = key_low_reg;
                            s_next[3]        = in_item.nonce_high;
                            s_next[4]        = in_item.nonce_low;
                            rnd_next         = RND_FIRST_FULL;
                            post_key_next    = 1'b1;
                            emit_next        = 1'b0;
                            domain_done_next = 1'b0;
                            ad_seen_next     = 1'b0;
                            state_next       = ST_ROUND;
                        end
                        OP_AD:
                        begin
                            if (!domain_done_reg)
                            begin
                                if (!in_item.last)
                                begin
                                    s_next[0]     = s_reg[0] ^ in_item.block;
                                    rnd_next      = RND_FIRST_HALF;
                                    post_key_next = 1'b0;
                                    emit_next     = 1'b0;
                                    ad_seen_next  = 1'b1;
                                    state_next    = ST_ROUND;
                                end
                                else if (n_sat != 3'd0 || ad_seen_reg)
                                begin
                                    s_next[0] = s_reg[0]
                                              ^ (in_item.block & lead_mask({1'b0, n_sat}))
                                              ^ pad_word(n_sat);
                                    rnd_next      = RND_FIRST_HALF;
                                    post_key_next = 1'b0;
                                    emit_next     = 1'b0;
                                    ad_seen_next  = 1'b1;
                                    state_next    = ST_ROUND;
                                end
                            end
                        end
                        OP_MSG:
                        begin
                            if (!domain_done_reg)
                            begin
                                s_next[4] = s_reg[4] ^ 64'd1;
                            end
                            domain_done_next = 1'b1;
                            if (decrypt_mode_reg)
                            begin
                                pend_data_next = (s_reg[0] ^ msg_d) & msg_mask;
                                s_next[0]      = (s_reg[0] & ~msg_mask) | msg_d;
                            end
                            else
                            begin
                                pend_data_next = (s_reg[0] ^ msg_d) & msg_mask;
                                s_next[0]      = s_reg[0] ^ msg_d;
                            end
                            pend_kind_next  = KIND_DATA;
                            pend_bytes_next = nb;
                            post_key_next   = 1'b0;
                            emit_next       = 1'b1;
                            if (in_item.last)
                            begin
                                s_next[0]  = s_next[0] ^ pad_word(nb[2:0]);
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                rnd_next   = RND_FIRST_HALF;
                                state_next = ST_ROUND;
                            end
                        end
                        OP_FINAL:
                        begin
                            s_next[1]      = s_reg[1] ^ key_high_reg;
                            s_next[2]      = s_reg[2] ^ key_low_reg;
                            rnd_next       = RND_FIRST_FULL;
                            post_key_next  = 1'b1;
                            emit_next      = 1'b1;
                            pend_kind_next = decrypt_mode_reg ? KIND_VERIFY : KIND_TAG1;
                            tag_high_next  = in_item.tag_high;
                            tag_low_next   = in_item.tag_low;
                            state_next     = ST_ROUND;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROUND:
            begin
                s_next   = s_round;
                rnd_next = rnd_reg + RND_W'(1);
                if (rnd_reg == RND_LAST)
                begin
                    if (post_key_reg)
                    begin
                        s_next[3] = s_round[3] ^ key_high_reg;
                        s_next[4] = s_round[4] ^ key_low_reg;
                    end
                    state_next = emit_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    case (pend_kind_reg)
                        KIND_DATA:
                        begin
                            out_item_next = '{kind: KIND_DATA, out_data: pend_data_reg,
                                              out_bytes: pend_bytes_reg, auth_ok: 1'b0,
                                              final_result: 1'b1};
                            state_next    = ST_IDLE;
                        end
                        KIND_TAG1:
                        begin
                            out_item_next = '{kind: KIND_TAG1, out_data: s_reg[3],
                                              out_bytes: 4'd8, auth_ok: 1'b0,
                                              final_result: 1'b0};
                            state_next    = ST_TAG2;
                        end
                        KIND_VERIFY:
                        begin
                            out_item_next = '{kind: KIND_VERIFY, out_data: 64'd0,
                                              out_bytes: 4'd0,
                                              auth_ok: (s_reg[3] == tag_high_reg)
                                                    && (s_reg[4] == tag_low_reg),
                                              final_result: 1'b1};
                            state_next    = ST_IDLE;
                        end
                        default:
                        begin
                            out_item_next = '{kind: KIND_TAG2, out_data: s_reg[4],
                                              out_bytes: 4'd8, auth_ok: 1'b0,
                                              final_result: 1'b1};
                            state_next    = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TAG2:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_item_next = '{kind: KIND_TAG2, out_data: s_reg[4],
                                      out_bytes: 4'd8, auth_ok: 1'b0,
                                      final_result: 1'b1};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, sponge state, output valid and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            s_reg            <= '0;
            rnd_reg          <= '0;
            post_key_reg     <= 1'b0;
            emit_reg         <= 1'b0;
            domain_done_reg  <= 1'b0;
            ad_seen_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            key_high_reg     <= '0;
            key_low_reg      <= '0;
            decrypt_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            s_reg           <= s_next;
            rnd_reg         <= rnd_next;
            post_key_reg    <= post_key_next;
            emit_reg        <= emit_next;
            domain_done_reg <= domain_done_next;
            ad_seen_reg     <= ad_seen_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_KEY_HIGH: key_high_reg     <= cfg_data;
                    REG_KEY_LOW:  key_low_reg      <= cfg_data;
                    REG_DECRYPT:  decrypt_mode_reg <= cfg_data[0];
                    default:      key_high_reg     <= key_high_reg;
                endcase
            end
        end
    end

    // payload holding registers
    always_ff @(posedge clk)
    begin
        pend_kind_reg  <= pend_kind_next;
        pend_data_reg  <= pend_data_next;
        pend_bytes_reg <= pend_bytes_next;
        tag_high_reg   <= tag_high_next;
        tag_low_reg    <= tag_low_next;
        out_item_reg   <= out_item_next;
    end

endmodule
